// ===== rtl/tha_pkg.sv =====
// Shared types and constants of the thrust allocation block.
package tha_pkg;

  // Fixed field widths, axis count, result limit and count reset value.
  localparam int AXES       = 6;
  localparam int AXIS_W     = 3;
  localparam int ID_W       = 3;
  localparam int CNT_W      = 4;
  localparam int CMD_W      = 24;
  localparam int COEF_W     = 24;
  localparam int THRUST_W   = 32;
  localparam int OUT_LIMIT  = 8;
  localparam int CNT_RESET  = 8;

  // Arithmetic widths: exact Q.24 sum, Q.8 effort, scaled product, Q.8 thrust.
  localparam int MUL_W      = CMD_W + COEF_W;
  localparam int ACC_W      = MUL_W + 3;
  localparam int EFF_W      = ACC_W - 16;
  localparam int PROD_W     = EFF_W + COEF_W;
  localparam int T_W        = PROD_W - 16;

  // Gain of 1.0 in Q8.16.
  localparam logic signed [COEF_W-1:0] GAIN_ONE = COEF_W'(65536);

  // Request function codes.
  typedef enum logic [1:0] {
    FUNC_COEFF    = 2'd0,
    FUNC_FWD_GAIN = 2'd1,
    FUNC_BWD_GAIN = 2'd2,
    FUNC_APPLY    = 2'd3
  } tha_func_e;

  // Payload of one input request as seen by the datapath.
  typedef struct packed {
    logic [AXIS_W-1:0]            thruster_sel;
    logic [AXIS_W-1:0]            axis_sel;
    logic [COEF_W-1:0]            load_value;
    logic [AXES-1:0][CMD_W-1:0]   cmd;
  } tha_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              wr_coeff;
    logic              wr_fwd;
    logic              wr_bwd;
    logic              cmd_load;
    logic              mac_rd;
    logic              acc_clr;
    logic              round;
    logic              scale;
    logic              res_load;
    logic              res_last;
    logic [ID_W-1:0]   row;
    logic [AXIS_W-1:0] axis;
  } tha_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic res_full;
  } tha_sts_t;

endpackage

// ===== rtl/tha_if.sv =====
// Channel interfaces of the thrust allocation block.
interface tha_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [2:0]         thruster_sel;
  logic [2:0]         axis_sel;
  logic signed [23:0] load_value;
  logic signed [23:0] force_x;
  logic signed [23:0] force_y;
  logic signed [23:0] force_z;
  logic signed [23:0] torque_x;
  logic signed [23:0] torque_y;
  logic signed [23:0] torque_z;

  modport source (
    output valid, func, thruster_sel, axis_sel, load_value,
           force_x, force_y, force_z, torque_x, torque_y, torque_z,
    input  ready
  );
  modport sink (
    input  valid, func, thruster_sel, axis_sel, load_value,
           force_x, force_y, force_z, torque_x, torque_y, torque_z,
    output ready
  );
endinterface

interface tha_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         thruster_id;
  logic signed [31:0] thrust;
  logic               last;

  modport source (output valid, thruster_id, thrust, last, input ready);
  modport sink (input valid, thruster_id, thrust, last, output ready);
endinterface

interface tha_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/tha_ctrl.sv =====
// Controller state machine of the thrust allocation block.
module tha_ctrl #(
  parameter int MAX_THRUSTERS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [1:0]               in_func_i,
  output logic                     in_ready_o,
  input  logic                     cfg_valid_i,
  input  logic [tha_pkg::CNT_W-1:0] cfg_data_i,
  output logic                     cfg_ready_o,
  input  tha_pkg::tha_sts_t        sts_i,
  output tha_pkg::tha_ctl_t        ctl_o
);
  import tha_pkg::*;

  localparam int LIM = (MAX_THRUSTERS < OUT_LIMIT) ? MAX_THRUSTERS : OUT_LIMIT;
  localparam logic [CNT_W-1:0] LIM_C = CNT_W'(LIM);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MAC    = 7'b0000010,
    ST_DRAIN1 = 7'b0000100,
    ST_DRAIN2 = 7'b0001000,
    ST_ROUND  = 7'b0010000,
    ST_SCALE  = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } tha_state_e;

  tha_state_e        state_q, state_d;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  n_q, n_d, n_clamp;
  logic [ID_W-1:0]   row_q, row_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  logic              accept;
  logic              last;

  // The thruster count register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(CNT_RESET);
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // Active thruster count, clamped to the storage and to the result limit.
  assign n_clamp = (count_q > LIM_C) ? LIM_C : count_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last       = ((CNT_W'(row_q) + CNT_W'(1)) == n_q);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    row_d   = row_q;
    axis_d  = axis_q;
    ctl_o   = '0;
    ctl_o.row  = row_q;
    ctl_o.axis = axis_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (tha_func_e'(in_func_i))
            FUNC_COEFF:    ctl_o.wr_coeff = 1'b1;
            FUNC_FWD_GAIN: ctl_o.wr_fwd   = 1'b1;
            FUNC_BWD_GAIN: ctl_o.wr_bwd   = 1'b1;
            FUNC_APPLY: begin
              ctl_o.cmd_load = 1'b1;
              n_d    = n_clamp;
              row_d  = '0;
              axis_d = '0;
              if (n_clamp != '0) begin
                state_d = ST_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        ctl_o.mac_rd  = 1'b1;
        ctl_o.acc_clr = (axis_q == '0);
        if (axis_q == AXIS_W'(AXES - 1)) begin
          axis_d  = '0;
          state_d = ST_DRAIN1;
        end else begin
          axis_d = axis_q + AXIS_W'(1);
        end
      end
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_ROUND;
      ST_ROUND: begin
        ctl_o.round = 1'b1;
        state_d     = ST_SCALE;
      end
      ST_SCALE: begin
        ctl_o.scale = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.res_full) begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_last = last;
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            row_d   = row_q + ID_W'(1);
            state_d = ST_MAC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      row_q   <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      row_q   <= row_d;
      axis_q  <= axis_d;
    end
  end

  // The thruster being worked on is always one of the active ones.
  a_row_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (CNT_W'(row_q) < n_q))
    else $error("thruster index beyond active count");

  // A result is only loaded into a free output register.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.res_load |-> !sts_i.res_full)
    else $error("result loaded over a waiting result");

  // Rounding is always followed by the gain multiply.
  a_round_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |=> (state_q == ST_SCALE))
    else $error("gain multiply skipped");

  // An apply request with no active thruster leaves the block idle.
  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.cmd_load && (n_clamp == '0)) |=> (state_q == ST_IDLE))
    else $error("work started with no active thruster");

endmodule

// ===== rtl/tha_datapath.sv =====
// Datapath: coefficient memory, gains, multiply-accumulate, scaling and result register.
module tha_datapath #(
  parameter int MAX_THRUSTERS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tha_pkg::tha_item_t            item_i,
  input  tha_pkg::tha_ctl_t             ctl_i,
  output tha_pkg::tha_sts_t             sts_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [tha_pkg::ID_W-1:0]      res_id_o,
  output logic signed [tha_pkg::THRUST_W-1:0] res_thrust_o,
  output logic                          res_last_o
);
  import tha_pkg::*;

  localparam int DEPTH  = MAX_THRUSTERS * AXES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = (MAX_THRUSTERS > 1) ? $clog2(MAX_THRUSTERS) : 1;
  localparam logic signed [ACC_W-1:0]  RND_ACC  = ACC_W'(32768);
  localparam logic signed [PROD_W-1:0] RND_PROD = PROD_W'(32768);

  logic signed [COEF_W-1:0] coeff_mem [DEPTH];
  logic signed [COEF_W-1:0] fwd_q [MAX_THRUSTERS];
  logic signed [COEF_W-1:0] bwd_q [MAX_THRUSTERS];
  logic [AXES-1:0][CMD_W-1:0] cmd_q;

  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic                     row_ok, axis_ok;
  logic signed [COEF_W-1:0] rd_q;
  logic signed [CMD_W-1:0]  sel_q;
  logic                     v1_q, v2_q;
  logic signed [MUL_W-1:0]  mul_q;
  logic signed [ACC_W-1:0]  acc_q, acc_rnd;
  logic signed [EFF_W-1:0]  eff_q;
  logic signed [COEF_W-1:0] gain_q;
  logic signed [PROD_W-1:0] prod_q, prod_rnd;
  logic signed [T_W-1:0]    t_full;
  logic signed [THRUST_W-1:0] t_sat;
  logic                     t_fits;
  logic                     out_vld_q;
  logic [ID_W-1:0]          out_id_q;
  logic signed [THRUST_W-1:0] out_thrust_q;
  logic                     out_last_q;

  // Load addressing; rows beyond the storage and axis indices of six and above are dropped.
  assign row_ok  = (32'(item_i.thruster_sel) < MAX_THRUSTERS);
  assign axis_ok = (item_i.axis_sel < AXIS_W'(AXES));
  assign wr_addr = ADDR_W'(32'(item_i.thruster_sel) * AXES + 32'(item_i.axis_sel));
  assign rd_addr = ADDR_W'(32'(ctl_i.row) * AXES + 32'(ctl_i.axis));

  // Coefficient memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_coeff && row_ok && axis_ok) begin
      coeff_mem[wr_addr] <= item_i.load_value;
    end
    if (ctl_i.mac_rd) begin
      rd_q  <= coeff_mem[rd_addr];
      sel_q <= cmd_q[ctl_i.axis];
    end
  end

  // Gain registers, reset to 1.0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_THRUSTERS; i++) begin
        fwd_q[i] <= GAIN_ONE;
        bwd_q[i] <= GAIN_ONE;
      end
    end else begin
      if (ctl_i.wr_fwd && row_ok) begin
        fwd_q[ROW_W'(item_i.thruster_sel)] <= item_i.load_value;
      end
      if (ctl_i.wr_bwd && row_ok) begin
        bwd_q[ROW_W'(item_i.thruster_sel)] <= item_i.load_value;
      end
    end
  end

  // Command axes captured on an apply request.
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd_load) begin
      cmd_q <= item_i.cmd;
    end
  end

  // Multiply-accumulate pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.mac_rd;
      v2_q <= v1_q;
    end
  end

  // Product of one axis, then the exact Q.24 sum.
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      mul_q <= rd_q * sel_q;
    end
    if (ctl_i.acc_clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(mul_q);
    end
  end

  // Round the effort to Q.8 and pick the gain by the sign of the exact sum.
  assign acc_rnd = acc_q + RND_ACC;

  always_ff @(posedge clk_i) begin
    if (ctl_i.round) begin
      eff_q  <= acc_rnd[ACC_W-1:16];
      gain_q <= (!acc_q[ACC_W-1] && (acc_q != '0)) ? fwd_q[ROW_W'(ctl_i.row)]
                                                  : bwd_q[ROW_W'(ctl_i.row)];
    end
    if (ctl_i.scale) begin
      prod_q <= eff_q * gain_q;
    end
  end

  // Round the scaled value to Q.8 and saturate to 32 bits.
  assign prod_rnd = prod_q + RND_PROD;
  assign t_full   = prod_rnd[PROD_W-1:16];
  assign t_fits   = (t_full[T_W-1:THRUST_W-1] == '0) || (t_full[T_W-1:THRUST_W-1] == '1);
  assign t_sat    = t_fits ? t_full[THRUST_W-1:0]
                  : (t_full[T_W-1] ? {1'b1, {(THRUST_W-1){1'b0}}}
                                   : {1'b0, {(THRUST_W-1){1'b1}}});

  // Output register; it holds a result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctl_i.res_load) begin
      out_vld_q <= 1'b1;
    end else if (res_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      out_id_q     <= ctl_i.row;
      out_thrust_q <= t_sat;
      out_last_q   <= ctl_i.res_last;
    end
  end

  assign sts_o.res_full = out_vld_q && !res_ready_i;
  assign res_valid_o    = out_vld_q;
  assign res_id_o       = out_id_q;
  assign res_thrust_o   = out_thrust_q;
  assign res_last_o     = out_last_q;

endmodule

// ===== rtl/thrust_allocation_apply.sv =====
// Top level of the thrust allocation block.
//
//   channel  direction  payload                                       handshake
//   in_i     sink       func, thruster_sel, axis_sel, load_value,     valid/ready
//                       force_x/y/z, torque_x/y/z
//   out_o    source     thruster_id, thrust, last                     valid/ready
//   cfg_i    sink       data (thruster_count)                         valid/ready
//
// An apply request, once accepted, works through each active thruster in turn:
// six coefficient reads through the single memory read port and shared multiplier,
// the drain states ST_DRAIN1 and ST_DRAIN2, then rounding, gain multiply and the
// result load. Reset sets all gains to 1.0 and the thruster count to 8; the
// coefficient memory is not cleared. A result waits in the output register while
// out_o is stalled, and the next one is held back until it leaves.
module thrust_allocation_apply #(
  parameter int MAX_THRUSTERS = 8
) (
  input logic       clk_i,
  input logic       rst_ni,
  tha_in_if.sink    in_i,
  tha_out_if.source out_o,
  tha_cfg_if.sink   cfg_i
);
  import tha_pkg::*;

  tha_item_t item;
  tha_ctl_t  ctl;
  tha_sts_t  sts;
  logic      in_ready;
  logic      cfg_ready;

  // Gather the request payload for the datapath.
  assign item.thruster_sel = in_i.thruster_sel;
  assign item.axis_sel     = in_i.axis_sel;
  assign item.load_value   = in_i.load_value;
  assign item.cmd[0]       = in_i.force_x;
  assign item.cmd[1]       = in_i.force_y;
  assign item.cmd[2]       = in_i.force_z;
  assign item.cmd[3]       = in_i.torque_x;
  assign item.cmd[4]       = in_i.torque_y;
  assign item.cmd[5]       = in_i.torque_z;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = cfg_ready;

  tha_ctrl #(
    .MAX_THRUSTERS(MAX_THRUSTERS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .in_ready_o  (in_ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  tha_datapath #(
    .MAX_THRUSTERS(MAX_THRUSTERS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .res_valid_o  (out_o.valid),
    .res_ready_i  (out_o.ready),
    .res_id_o     (out_o.thruster_id),
    .res_thrust_o (out_o.thrust),
    .res_last_o   (out_o.last)
  );

endmodule

// ===== test/thrust_allocation_apply_tb.sv =====
// Self-checking testbench for the thrust allocation block: directed and random traffic against a predictor.
module thrust_allocation_apply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tha_pkg::*;

  localparam int MAX_ROWS     = 8;
  localparam int AXIS_COUNT   = 6;
  localparam int DRAIN_CYCLES = 120;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS  = 35;

  // One input request as the testbench builds it.
  typedef struct packed {
    tha_func_e        func;
    logic [2:0]       sel;
    logic [2:0]       axis;
    logic [23:0]      load;
    logic [5:0][23:0] cmd;
  } thrust_req_t;

  // One expected thrust result.
  typedef struct {
    logic [2:0]         id;
    logic signed [31:0] thrust;
    logic               last;
  } thrust_exp_t;

  // Allocation matrix, gains and count mirror, plus the queue of pending thrusts.
  class allocation_board;
    logic signed [23:0] coeff [MAX_ROWS][AXIS_COUNT];
    logic signed [23:0] fwd_gain [MAX_ROWS];
    logic signed [23:0] bwd_gain [MAX_ROWS];
    logic [3:0]         active_count;
    thrust_exp_t        thrust_q [$];
    int                 errors;

    function new();
      for (int i = 0; i < MAX_ROWS; i++) begin
        fwd_gain[i] = GAIN_ONE;
        bwd_gain[i] = GAIN_ONE;
        for (int a = 0; a < AXIS_COUNT; a++) coeff[i][a] = '0;
      end
      active_count = 4'd8;
      errors = 0;
    endfunction

    function void set_count(logic [3:0] value);
      active_count = value;
    endfunction

    function int pending();
      return thrust_q.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    endfunction

    // Dot product, gain by sign, two roundings to Q.8 and saturation.
    function logic signed [31:0] predicted_thrust(logic [5:0][23:0] cmd, int row);
      longint effort;
      longint eff8;
      longint prod;
      longint t;
      logic signed [23:0] gain;
      effort = 0;
      for (int a = 0; a < AXIS_COUNT; a++)
        effort += longint'($signed(cmd[a])) * longint'(coeff[row][a]);
      gain = (effort > 0) ? fwd_gain[row] : bwd_gain[row];
      eff8 = (effort + 64'sd32768) >>> 16;
      prod = eff8 * longint'(gain);
      t = (prod + 64'sd32768) >>> 16;
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return t[31:0];
    endfunction

    // Update the mirror for a load, or queue the thrusts an apply produces.
    function void note_request(thrust_req_t r);
      int n;
      thrust_exp_t e;
      if (r.func != FUNC_APPLY) begin
        if (r.sel < MAX_ROWS) begin
          case (r.func)
            FUNC_COEFF:    if (r.axis < AXIS_COUNT) coeff[r.sel][r.axis] = r.load;
            FUNC_FWD_GAIN: fwd_gain[r.sel] = r.load;
            default:       bwd_gain[r.sel] = r.load;
          endcase
        end
        return;
      end
      n = (active_count > MAX_ROWS) ? MAX_ROWS : int'(active_count);
      for (int i = 0; i < n; i++) begin
        e.id     = i[2:0];
        e.thrust = predicted_thrust(r.cmd, i);
        e.last   = (i == n - 1);
        thrust_q.push_back(e);
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [2:0] id, logic signed [31:0] thrust, logic last);
      thrust_exp_t e;
      if (thrust_q.size() == 0) begin
        report($sformatf("unexpected result: id %0d thrust %0d last %0b", id, thrust, last));
        return;
      end
      e = thrust_q.pop_front();
      if (id !== e.id)
        report($sformatf("thruster_id mismatch: expected %0d, got %0d", e.id, id));
      if (thrust !== e.thrust)
        report($sformatf("thrust mismatch on thruster %0d: expected %0d, got %0d",
                         e.id, e.thrust, thrust));
      if (last !== e.last)
        report($sformatf("last mismatch on thruster %0d: expected %0b, got %0b",
                         e.id, e.last, last));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tha_in_if  in_if ();
  tha_out_if out_if ();
  tha_cfg_if cfg_if ();

  thrust_allocation_apply #(
    .MAX_THRUSTERS(MAX_ROWS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  allocation_board board = new();

  // Coefficients written so far; apply requests never read an unwritten one.
  logic coeff_loaded [MAX_ROWS][AXIS_COUNT];
  int   burst_left;
  logic [3:0] count_now;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // Signed value spread over small, unit-scale, extreme and full-range magnitudes.
  function automatic logic [23:0] gen_value();
    int v;
    case ($urandom_range(0, 5))
      0: v = int'($urandom_range(0, 2047)) - 1024;
      1: v = int'($urandom_range(0, 262143)) - 131072;
      2: begin
        case ($urandom_range(0, 4))
          0:       v = 8388607;
          1:       v = -8388608;
          2:       v = 0;
          3:       v = 1;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom);
    endcase
    return v[23:0];
  endfunction

  function automatic thrust_req_t make_load(tha_func_e func, int row, int axis,
                                            logic [23:0] value);
    thrust_req_t r;
    r.func = func;
    r.sel  = row[2:0];
    r.axis = axis[2:0];
    r.load = value;
    r.cmd  = '0;
    if (func == FUNC_COEFF && axis < AXIS_COUNT) coeff_loaded[row][axis] = 1'b1;
    return r;
  endfunction

  function automatic thrust_req_t make_apply(logic [5:0][23:0] cmd);
    thrust_req_t r;
    r.func = FUNC_APPLY;
    r.sel  = 3'($urandom_range(0, 7));
    r.axis = 3'($urandom_range(0, 7));
    r.load = gen_value();
    r.cmd  = cmd;
    return r;
  endfunction

  // Random request; an apply that would read an unwritten coefficient becomes its write.
  function automatic thrust_req_t random_request(logic [3:0] cnt);
    thrust_req_t r;
    int pick;
    int n;
    int axis;
    logic [5:0][23:0] cmd;
    for (int a = 0; a < AXIS_COUNT; a++) cmd[a] = gen_value();
    pick = $urandom_range(0, 99);
    axis = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
    if (pick < 40) begin
      n = (cnt > MAX_ROWS) ? MAX_ROWS : int'(cnt);
      for (int i = 0; i < n; i++)
        for (int a = 0; a < AXIS_COUNT; a++)
          if (!coeff_loaded[i][a]) begin
            r = make_load(FUNC_COEFF, i, a, gen_value());
            r.cmd = cmd;
            return r;
          end
      r = make_apply(cmd);
    end else if (pick < 70) begin
      r = make_load(FUNC_COEFF, $urandom_range(0, 7), axis, gen_value());
    end else if (pick < 85) begin
      r = make_load(FUNC_FWD_GAIN, $urandom_range(0, 7), axis, gen_value());
    end else begin
      r = make_load(FUNC_BWD_GAIN, $urandom_range(0, 7), axis, gen_value());
    end
    r.cmd = cmd;
    return r;
  endfunction

  // Send one request; bursts of random length separated by random gaps.
  task automatic send_request(thrust_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
    end
    in_if.func         <= r.func;
    in_if.thruster_sel <= r.sel;
    in_if.axis_sel     <= r.axis;
    in_if.load_value   <= r.load;
    in_if.force_x      <= r.cmd[0];
    in_if.force_y      <= r.cmd[1];
    in_if.force_z      <= r.cmd[2];
    in_if.torque_x     <= r.cmd[3];
    in_if.torque_y     <= r.cmd[4];
    in_if.torque_z     <= r.cmd[5];
    in_if.valid        <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    board.note_request(r);
    @(negedge clk);
    burst_left--;
  endtask

  // Write the thruster count while the block is idle.
  task automatic write_count(logic [3:0] value);
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    board.set_count(value);
    count_now = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Hold off the sender until every expected thrust has come, then let the block settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Result receiver: always ready, random stalls, or long stall runs.
  initial begin
    int   mode;
    int   mode_left;
    int   run_left;
    logic run_ready;
    mode_left = 0;
    run_left  = 0;
    run_ready = 1'b0;
    mode      = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (run_left == 0) begin
            run_ready = !run_ready;
            run_left  = run_ready ? $urandom_range(1, 8) : $urandom_range(1, 15);
          end
          run_left--;
          out_if.ready <= run_ready;
        end
      endcase
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      board.check_result(out_if.thruster_id, out_if.thrust, out_if.last);
  end

  // Main stimulus.
  initial begin
    logic [3:0] phase_count [8];
    phase_count = '{4'd3, 4'd8, 4'd15, 4'd0, 4'd5, 4'd8, 4'd1, 4'd0};
    phase_count[7] = 4'($urandom_range(0, 15));
    for (int i = 0; i < MAX_ROWS; i++)
      for (int a = 0; a < AXIS_COUNT; a++) coeff_loaded[i][a] = 1'b0;
    burst_left = 0;
    count_now  = 4'd8;

    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.func         = FUNC_COEFF;
    in_if.thruster_sel = '0;
    in_if.axis_sel     = '0;
    in_if.load_value   = '0;
    in_if.force_x      = '0;
    in_if.force_y      = '0;
    in_if.force_z      = '0;
    in_if.torque_x     = '0;
    in_if.torque_y     = '0;
    in_if.torque_z     = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.data        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: one thruster with the largest coefficients to reach both saturations.
    write_count(4'd1);
    for (int a = 0; a < AXIS_COUNT; a++)
      send_request(make_load(FUNC_COEFF, 0, a, 24'h7FFFFF));
    // Writes to axis 6 and 7 must leave the matrix alone.
    send_request(make_load(FUNC_COEFF, 0, 6, 24'h800000));
    send_request(make_load(FUNC_COEFF, 0, 7, 24'h123456));
    send_request(make_apply({6{24'h7FFFFF}}));
    send_request(make_apply({6{24'h800000}}));
    // Zero effort takes the backward gain.
    send_request(make_apply('0));
    // Extreme gains in both directions.
    send_request(make_load(FUNC_FWD_GAIN, 0, 0, 24'h7FFFFF));
    send_request(make_load(FUNC_BWD_GAIN, 0, 0, 24'h800000));
    send_request(make_apply({6{24'h000003}}));
    send_request(make_apply({6{24'hFFFFFD}}));
    send_request(make_load(FUNC_COEFF, 0, 0, 24'h800000));
    send_request(make_apply({24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'h7FFFFF}));
    drain();
    // A zero count makes an apply produce nothing.
    write_count(4'd0);
    send_request(make_apply({6{24'h000100}}));
    drain();

    // Random phases, each under its own thruster count.
    foreach (phase_count[p]) begin
      write_count(phase_count[p]);
      repeat (PHASE_ITEMS) send_request(random_request(count_now));
      drain();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
